// ===== design/mram_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mram_pkg;
    localparam int FRAME_BYTES     = 64;
    localparam int SLAVE_COUNT     = 63;
    localparam int WORDS_PER_SLAVE = 7;
    localparam int FB_W  = $clog2(FRAME_BYTES);
    localparam int CNT_W = $clog2(FRAME_BYTES + 2);
    localparam int SL_W  = $clog2(SLAVE_COUNT);
    localparam int WI_W  = $clog2(WORDS_PER_SLAVE);
    localparam int WA_W  = $clog2(SLAVE_COUNT * WORDS_PER_SLAVE);

    localparam logic [2:0] REG_CO    = 3'd0;
    localparam logic [2:0] REG_MULTI = 3'd1;
    localparam logic [2:0] REG_WIND  = 3'd2;
    localparam logic [2:0] REG_CO2   = 3'd3;
    localparam logic [2:0] REG_TH    = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  src_addr;
        logic [7:0]  sensor_model;
        logic        alarm_changed;
        logic        alarm_state;
        logic [31:0] crc_error_count;
        logic [31:0] zero_addr_count;
    } t_out;

    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (x[0]) x = (x >> 1) ^ 16'hA001;
            else      x = x >> 1;
        end
        return x;
    endfunction
endpackage
`default_nettype wire

// ===== design/modbus_response_alarm_monitor_core.sv =====
// Modbus RTU response checker with per-slave alarm tracking. One byte is taken per
// transaction; an ordinary byte gets a CRC step and a frame buffer write. On the
// byte carrying frame_end the block runs a commit sequencer over the frame buffer and
// the sensor word memory, one buffer read per cycle: header reads (S_HDR), a decision
// (S_HDRW), then, for a frame that passes it, per word either a read, high byte and
// write (S_WHI, S_WLO, S_WRD) when the word is stored or S_WHI alone when it is kept,
// then the alarm decision (S_JUDGE). The next byte is taken once the result has been
// accepted and the block is back in idle.
// After reset a clearing pass over all SLAVE_COUNT*WORDS_PER_SLAVE (441) word
// locations zeroes the word memory and the alarm flags; no byte is accepted during it.
// Configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module modbus_response_alarm_monitor_core import mram_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in        i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out            o_data,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_addr,
    input  wire logic [7:0] i_cfg_wdata
);
    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HDR   = 9'b000000100,
        S_HDRW  = 9'b000001000,
        S_WHI   = 9'b000010000,
        S_WLO   = 9'b000100000,
        S_WRD   = 9'b001000000,
        S_JUDGE = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    logic [7:0] r_code_co, r_code_multi, r_code_wind, r_code_co2, r_code_th;
    logic [7:0] r_fbuf [FRAME_BYTES];
    logic [7:0] r_fb_q;
    logic [15:0] r_wmem [SLAVE_COUNT * WORDS_PER_SLAVE];
    logic [15:0] r_wm_q;
    logic r_fmem [SLAVE_COUNT];
    logic r_fl_q;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0] r_crc;
    logic [31:0] r_crc_err, r_zero;
    logic [WA_W-1:0] r_clr;
    logic [3:0] r_hstep;
    logic [7:0] r_slave, r_bc, r_model, r_hi;
    logic [CNT_W-1:0] r_len;
    logic [WI_W:0] r_wi;
    logic [15:0] r_w [WORDS_PER_SLAVE];
    logic r_ok, r_valid;
    t_out r_out;

    logic acc, last_byte, fb_we, wm_we, wm_adv, fl_we, fl_wd;
    logic [15:0] n_crc;
    logic [FB_W-1:0] fb_ra;
    logic [WA_W-1:0] wm_ra, wm_wa, base;
    logic [15:0] wm_wd;
    logic [SL_W-1:0] sidx, fl_wa;
    logic [8:0] payload_len;
    logic word_ok, nxt, cur;

    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign acc = i_valid && !o_stall;
    assign last_byte = acc && i_data.frame_end;
    assign n_crc = crc_update(r_crc, i_data.rx_byte);
    assign o_valid = r_valid;
    assign o_data = r_out;
    assign sidx = SL_W'(r_slave - 8'd1);
    assign base = WA_W'(sidx * WORDS_PER_SLAVE);
    assign payload_len = (r_bc >= 8'd1) ? {1'b0, r_bc} - 9'd1 : 9'd0;
    assign word_ok = (r_wi < (WI_W+1)'(WORDS_PER_SLAVE))
        && ({{(7-WI_W){1'b0}}, r_wi, 1'b1} < payload_len)
        && ((11)'({r_wi, 1'b0}) + 11'd8 <= (11)'(r_len));

    always_comb begin
        fb_ra = '0;
        if (r_state == S_HDR) fb_ra = FB_W'(r_hstep);
        else fb_ra = FB_W'({r_wi, 1'b0} + 4 + (r_state == S_WLO ? 1 : 0));
        if (last_byte) fb_ra = '0;
        // fetch the following word whenever r_wi moves on, except after the last word
        wm_adv = ((r_state == S_WRD) || (r_state == S_WHI && !word_ok))
            && (r_wi != (WI_W+1)'(WORDS_PER_SLAVE - 1));
        wm_ra = WA_W'(base + WA_W'(r_wi) + WA_W'(wm_adv));
    end

    always_comb begin
        fb_we = acc && (r_cnt < CNT_W'(FRAME_BYTES));
        wm_we = 1'b0;
        wm_wa = WA_W'(base + WA_W'(r_wi));
        wm_wd = {r_hi, r_fb_q};
        if (r_state == S_CLR) begin
            wm_we = 1'b1; wm_wa = r_clr; wm_wd = '0;
        end else if (r_state == S_WRD) wm_we = 1'b1;
    end

    always_comb begin
        fl_we = 1'b0;
        fl_wa = sidx;
        fl_wd = nxt;
        if (r_state == S_CLR) begin
            fl_we = (r_clr < WA_W'(SLAVE_COUNT));
            fl_wa = r_clr[SL_W-1:0];
            fl_wd = 1'b0;
        end else if (r_state == S_JUDGE) fl_we = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) r_fbuf[r_cnt[FB_W-1:0]] <= i_data.rx_byte;
        r_fb_q <= r_fbuf[fb_ra];
        if (wm_we) r_wmem[wm_wa] <= wm_wd;
        r_wm_q <= r_wmem[wm_ra];
        if (fl_we) r_fmem[fl_wa] <= fl_wd;
        r_fl_q <= r_fmem[sidx];
    end

    // hysteresis decision on the slave's (possibly updated) words
    always_comb begin
        cur = r_fl_q;
        nxt = cur;
        if (r_model == r_code_co) begin
            if (!cur && r_w[0] > 16'd2500) nxt = 1'b1;
            if (cur && r_w[0] < 16'd2000) nxt = 1'b0;
        end else if (r_model == r_code_multi) begin
            if (!cur && (r_w[0] > 16'd1000 || r_w[1] > 16'd80 || r_w[2] > 16'd600
                    || r_w[3] > 16'd35 || r_w[4] > 16'd50)) nxt = 1'b1;
            if (cur && r_w[0] < 16'd800 && r_w[1] < 16'd70 && r_w[2] < 16'd500
                    && r_w[3] < 16'd25 && r_w[4] < 16'd40) nxt = 1'b0;
        end else if (r_model == r_code_wind) begin
            if (!cur && r_w[0] > 16'd400) nxt = 1'b1;
            if (cur && r_w[0] < 16'd300) nxt = 1'b0;
        end else if (r_model == r_code_co2) begin
            if (!cur && r_w[0] > 16'd1000) nxt = 1'b1;
            if (cur && r_w[0] < 16'd800) nxt = 1'b0;
        end else if (r_model == r_code_th) begin
            if (!cur && r_w[1] > 16'd700) nxt = 1'b1;
            if (cur && r_w[1] < 16'd600) nxt = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_co <= 8'd1; r_code_multi <= 8'd2; r_code_wind <= 8'd3;
            r_code_co2 <= 8'd4; r_code_th <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CO:    r_code_co <= i_cfg_wdata;
                REG_MULTI: r_code_multi <= i_cfg_wdata;
                REG_WIND:  r_code_wind <= i_cfg_wdata;
                REG_CO2:   r_code_co2 <= i_cfg_wdata;
                REG_TH:    r_code_th <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_cnt <= '0; r_crc <= 16'hFFFF;
            r_crc_err <= '0; r_zero <= '0; r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == WA_W'(SLAVE_COUNT * WORDS_PER_SLAVE - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (acc) begin
                    // address byte kept aside in r_slave for the address checks
                    if (r_cnt == '0) r_slave <= i_data.rx_byte;
                    if (r_cnt <= CNT_W'(FRAME_BYTES)) r_cnt <= r_cnt + 1'b1;
                    r_crc <= n_crc;
                    if (i_data.frame_end) begin
                        r_len <= (r_cnt <= CNT_W'(FRAME_BYTES)) ? r_cnt + 1'b1 : r_cnt;
                        r_ok <= (r_cnt >= CNT_W'(3)) && (r_cnt < CNT_W'(FRAME_BYTES))
                             && (n_crc == 16'h0000);
                        r_hstep <= 4'd1; r_state <= S_HDR;
                    end
                end
                S_HDR: begin
                    // data of buffer address r_hstep-1 is in r_fb_q
                    r_hstep <= r_hstep + 1'b1;
                    if (r_hstep == 4'd3) r_bc <= r_fb_q;
                    if (r_hstep == 4'd4) begin
                        r_model <= r_fb_q; r_state <= S_HDRW; r_wi <= '0;
                    end
                end
                S_HDRW: begin
                    if (!r_ok) begin
                        r_crc_err <= r_crc_err + 1'b1; r_model <= '0; r_state <= S_OUT;
                    end else if (r_slave == 8'd0) begin
                        r_zero <= r_zero + 1'b1; r_model <= '0; r_state <= S_OUT;
                    end else if (r_slave > 8'(SLAVE_COUNT)) begin
                        r_model <= '0; r_state <= S_OUT;
                    end else begin
                        r_state <= S_WHI;
                    end
                end
                S_WHI: begin
                    // r_wm_q holds old word r_wi; fb read of high byte issued
                    if (r_wi < (WI_W+1)'(WORDS_PER_SLAVE)) r_w[r_wi[WI_W-1:0]] <= r_wm_q;
                    if (!word_ok) begin
                        r_wi <= r_wi + 1'b1;
                        if (r_wi >= (WI_W+1)'(WORDS_PER_SLAVE - 1)) r_state <= S_JUDGE;
                    end else r_state <= S_WLO;
                end
                S_WLO: begin r_hi <= r_fb_q; r_state <= S_WRD; end
                S_WRD: begin
                    r_w[r_wi[WI_W-1:0]] <= {r_hi, r_fb_q};
                    r_wi <= r_wi + 1'b1;
                    r_state <= (r_wi == (WI_W+1)'(WORDS_PER_SLAVE - 1)) ? S_JUDGE : S_WHI;
                end
                S_JUDGE: begin
                    r_out.alarm_changed <= nxt != cur;
                    r_out.alarm_state <= nxt;
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                    r_out.frame_ok <= r_ok; r_out.src_addr <= r_slave;
                    r_out.sensor_model <= r_model;
                    r_out.crc_error_count <= r_crc_err; r_out.zero_addr_count <= r_zero;
                end
                S_OUT: begin
                    r_state <= S_IDLE; r_cnt <= '0; r_crc <= 16'hFFFF;
                    if (!(r_ok && r_slave != 8'd0 && r_slave <= 8'(SLAVE_COUNT))) begin
                        r_valid <= 1'b1;
                        r_out.frame_ok <= r_ok; r_out.src_addr <= r_slave;
                        r_out.sensor_model <= '0; r_out.alarm_changed <= 1'b0;
                        r_out.alarm_state <= 1'b0;
                        r_out.crc_error_count <= r_crc_err;
                        r_out.zero_addr_count <= r_zero;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !acc) else $error("byte taken while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_out))) else $error("result lost");
    a_bad_no_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_out.frame_ok) |-> !r_out.alarm_changed) else $error("alarm on bad frame");
endmodule
`default_nettype wire
